// ===== rtl/core/character_range_expander_unit_assert.svh =====
// Assertion macros shared by the checker of the range expander.
// Needs only SystemVerilog concurrent assertions; no other file.
`ifndef CHARACTER_RANGE_EXPANDER_UNIT_ASSERT_SVH
`define CHARACTER_RANGE_EXPANDER_UNIT_ASSERT_SVH

// same-cycle implication
`define CRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define CRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/core/cre_pkg.sv =====
// Package of the character range expander: character constants, range test,
// and the command/status structs between controller and datapath.
`default_nettype none

package cre_pkg;

   localparam logic [7:0] DASH_CHAR  = 8'h2D;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;
   localparam logic [7:0] LOWER_LO   = 8'h61;
   localparam logic [7:0] LOWER_HI   = 8'h7A;
   localparam logic [7:0] UPPER_LO   = 8'h41;
   localparam logic [7:0] UPPER_HI   = 8'h5A;

   typedef struct packed {
      logic load;   // take the input word
      logic push;   // move one byte into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic emits;      // the input word yields at least one output word
      logic at_end;     // cursor sits on the closing byte
      logic slot_free;  // output register can take a word this cycle
   } dp_status_type;

   function automatic logic in_class(input logic [7:0] p, input logic [7:0] n,
                                     input logic [7:0] lo, input logic [7:0] hi);
      in_class = (p >= lo) && (p < hi) && (n > lo) && (n <= hi);
   endfunction

   function automatic logic forms_range(input logic [7:0] p, input logic [7:0] n);
      forms_range = in_class(p, n, DIGIT_LO, DIGIT_HI)
                 || in_class(p, n, LOWER_LO, LOWER_HI)
                 || in_class(p, n, UPPER_LO, UPPER_HI);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cre_if.sv =====
// Valid/ready channel interfaces of the range expander (request and response).
// Standalone; no package dependency.
`default_nettype none

interface cre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface cre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cre_ctrl.sv =====
// Controller of the range expander: idle/run sequencing of the datapath.
// Depends on cre_pkg.
`default_nettype none

module cre_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cre_pkg::dp_status_type status,
   output cre_pkg::dp_cmd_type         cmd
);
   import cre_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.push  = (state_ff == ST_RUN) && status.slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load && status.emits) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.push && status.at_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cre_datapath.sv =====
// Datapath of the range expander: string state, range cursor, output register.
// Depends on cre_pkg.
`default_nettype none

module cre_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          in_char,
   input  wire logic                in_last,
   input  wire cre_pkg::dp_cmd_type cmd,
   output cre_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               out_char,
   output logic                     out_last
);
   import cre_pkg::*;

   logic [7:0] prev_ff,   prev_in;
   logic       have_ff,   have_in;
   logic       dash_ff,   dash_in;
   logic [7:0] cursor_ff, cursor_in;
   logic [7:0] end_ff,    end_in;
   logic       last_ff,   last_in;
   logic       valid_ff,  valid_in;
   logic [7:0] char_ff,   char_in;
   logic       olast_ff,  olast_in;

   logic hold;
   logic range_go;

   // non-leading dash that is not final waits for its closing byte
   assign hold     = !dash_ff && (in_char == DASH_CHAR) && have_ff && !in_last;
   // descending pair would emit only the closing byte
   assign range_go = dash_ff && forms_range(prev_ff, in_char) && (in_char > prev_ff);

   assign status.emits     = !hold;
   assign status.at_end    = (cursor_ff == end_ff);
   assign status.slot_free = !valid_ff || rsp_ready;

   always_comb begin
      prev_in   = prev_ff;
      have_in   = have_ff;
      dash_in   = dash_ff;
      cursor_in = cursor_ff;
      end_in    = end_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && !rsp_ready;
      char_in   = char_ff;
      olast_in  = olast_ff;
      if (cmd.load) begin
         dash_in   = hold;
         have_in   = !in_last;
         prev_in   = in_last ? 8'h00 : (hold ? prev_ff : in_char);
         cursor_in = range_go ? prev_ff + 8'd1 : in_char;
         end_in    = in_char;
         last_in   = in_last;
      end
      if (cmd.push) begin
         valid_in  = 1'b1;
         char_in   = cursor_ff;
         olast_in  = last_ff && status.at_end;
         cursor_in = cursor_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 8'h00;
         have_ff  <= 1'b0;
         dash_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         have_ff  <= have_in;
         dash_ff  <= dash_in;
         valid_ff <= valid_in;
      end
      cursor_ff <= cursor_in;
      end_ff    <= end_in;
      last_ff   <= last_in;
      char_ff   <= char_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = olast_ff;

endmodule

`default_nettype wire

// ===== rtl/core/character_range_expander_unit.sv =====
// Flow: a word accepted in idle moves the controller to run, where the range
// cursor, one byte wide, pushes its bytes one by one into the output register
// whenever it has a free slot, so a stall on rsp holds the cursor. An input word
// yields N output words, N up to 25, and no new word is taken until the last one
// is pushed; a dash that is held yields none. Reset: synchronous, active high;
// clears string state and output valid; req ready is high in the cycle after reset.
`default_nettype none

module character_range_expander_unit (
   input  wire logic clock,
   input  wire logic reset,
   cre_req_if.sink   req_chan,
   cre_rsp_if.source rsp_chan
);
   import cre_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   cre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cre_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_char   (req_chan.in_char),
      .in_last   (req_chan.in_last),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .out_char  (rsp_chan.out_char),
      .out_last  (rsp_chan.out_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/cre_checker.sv =====
// Port-level checker of the range expander, bound to the top level.
// Depends on cre_pkg and character_range_expander_unit_assert.svh.
`default_nettype none

`include "character_range_expander_unit_assert.svh"

module cre_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_char,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char,
   input wire logic       rsp_last
);
   import cre_pkg::*;

   // a stalled output word holds
   `CRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char) && $stable(rsp_last))

   // idle and empty right after reset
   `CRE_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid)

   // a byte other than a dash always yields output, so the unit goes busy
   `CRE_ASSERT_NEXT(a_busy_after_byte, clock, reset, req_valid && req_ready && (req_char != DASH_CHAR), !req_ready)

   // while busy the output register is refilled whenever it drains
   `CRE_ASSERT_NEXT(a_refill, clock, reset, !req_ready && !rsp_valid, rsp_valid || req_ready)

endmodule

bind character_range_expander_unit cre_checker u_cre_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_char  (req_chan.in_char),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_char  (rsp_chan.out_char),
   .rsp_last  (rsp_chan.out_last)
);

`default_nettype wire
